@@ hdl/ppd_pkg.sv @@
`default_nettype none

package ppd_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int TRIGGER_BITS  = 12;
  localparam int COUNT_BITS    = 15;
  localparam int DIFF_BITS     = SAMPLE_BITS + 3;
  localparam int FALL_MARGIN   = 'h100;
  localparam int FALL_STEP     = 'h30;
  localparam int RISE_STEP     = 'h10;
  localparam int CLIP_MARGIN   = 15;
  localparam int CLIP_LEVEL    = (2 ** SAMPLE_BITS) - CLIP_MARGIN;
  localparam int PRODUCT_SHIFT = 6;
  localparam int PROD1_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int PROD2_BITS    = PROD1_BITS + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic signed [DIFF_BITS-1:0] diff_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL1,
    ST_MUL2,
    ST_EMIT
  } ppd_state_t;

  typedef struct packed {
    logic step;
    logic mul_first;
    logic mul_second;
    logic load;
  } ppd_cmd_t;

  typedef struct packed {
    logic finish;
    logic out_free;
  } ppd_status_t;

  function automatic diff_t widen(input logic [SAMPLE_BITS-1:0] x);
    return diff_t'({{(DIFF_BITS - SAMPLE_BITS){1'b0}}, x});
  endfunction

endpackage

`default_nettype wire

@@ hdl/ppd_if.sv @@
`default_nettype none

interface ppd_sample_if;
  import ppd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ppd_result_if;
  import ppd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COUNT_BITS-1:0]  pulse_width;
  logic [COUNT_BITS-1:0]  pulse_height;
  logic [COUNT_BITS-1:0]  clipped_count;
  logic [SAMPLE_BITS-1:0] rise_slope;
  modport source (output valid, output pulse_width, output pulse_height,
                  output clipped_count, output rise_slope, input ready);
  modport sink (input valid, input pulse_width, input pulse_height,
                input clipped_count, input rise_slope, output ready);
endinterface

interface ppd_cfg_if;
  import ppd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TRIGGER_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/particle_pulse_detector_unit.sv @@
// Particle pulse detector.
// The samples channel takes one detector sample per transaction and the
// results channel gives one transaction for every pulse that ends, carrying
// its width, corrected height, clipped sample count and rise slope.
// The cfg channel writes the trigger level; it is always ready and should be
// used only while no pulse result is outstanding.
// Samples are taken at one per cycle except while a pulse result is formed.
// A sample that ends a pulse holds the samples channel off while the clipping
// correction is formed by two registered multiplies in the datapath and its
// result is loaded into the output register behind the results channel.
// A result waits in the output register while the receiver stalls, and the
// block keeps taking samples meanwhile; it waits beyond the multiplies only if
// a second pulse ends before the first result has been taken.
// Reset clears the trigger level, the pulse state and the sample history to
// zero and leaves the results channel empty.

`default_nettype none

module particle_pulse_detector_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  ppd_sample_if.sink  samples,
  ppd_result_if.source results,
  ppd_cfg_if.sink     cfg
);
  import ppd_pkg::*;

  ppd_cmd_t    cmd;
  ppd_status_t status;
  logic        in_ready;

  assign samples.ready = in_ready;
  assign cfg.ready     = 1'b1;

  ppd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ppd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .sample        (samples.sample),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .pulse_width   (results.pulse_width),
    .pulse_height  (results.pulse_height),
    .clipped_count (results.clipped_count),
    .rise_slope    (results.rise_slope)
  );

endmodule

`default_nettype wire

@@ hdl/ppd_ctrl.sv @@
`default_nettype none

module ppd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ppd_pkg::ppd_status_t status,
  output ppd_pkg::ppd_cmd_t        cmd
);
  import ppd_pkg::*;

  ppd_state_t state;
  ppd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
        if (in_valid && status.finish) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_first = 1'b1;
        state_next    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_second = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  a_finish_starts_multiply: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && in_valid && status.finish) |=> (state == ST_MUL1))
    else $error("pulse end did not start the height correction");

  a_multiply_sequence: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL1) |=> (state == ST_MUL2))
    else $error("second multiply step skipped");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && status.out_free) |=> (state == ST_RUN))
    else $error("controller did not return after loading a result");

endmodule

`default_nettype wire

@@ hdl/ppd_datapath.sv @@
`default_nettype none

module ppd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [ppd_pkg::TRIGGER_BITS-1:0] cfg_data,
  input  wire logic [ppd_pkg::SAMPLE_BITS-1:0]  sample,
  input  wire ppd_pkg::ppd_cmd_t             cmd,
  output ppd_pkg::ppd_status_t               status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [ppd_pkg::COUNT_BITS-1:0]     pulse_width,
  output logic [ppd_pkg::COUNT_BITS-1:0]     pulse_height,
  output logic [ppd_pkg::COUNT_BITS-1:0]     clipped_count,
  output logic [ppd_pkg::SAMPLE_BITS-1:0]    rise_slope
);
  import ppd_pkg::*;

  logic [TRIGGER_BITS-1:0] trigger_level;
  logic                    in_pulse;
  logic [SAMPLE_BITS-1:0]  peak_height;
  logic [COUNT_BITS-1:0]   width_count;
  logic [COUNT_BITS-1:0]   clip_count;
  logic [SAMPLE_BITS-1:0]  start_slope;
  logic [SAMPLE_BITS-1:0]  last_sample;
  logic [SAMPLE_BITS-1:0]  sample_before_last;
  logic [PROD1_BITS-1:0]   prod_first;
  logic [PROD2_BITS-1:0]   prod_second;

  diff_t v_s;
  diff_t trig_s;
  diff_t last_s;
  diff_t before_s;
  diff_t peak_s;
  diff_t over;
  diff_t rise_step;
  diff_t three_quarter;
  diff_t fall_lhs;
  diff_t fall_rhs;
  diff_t rise_lhs;
  diff_t rise_rhs;
  logic  start;
  logic  finish;
  logic  clip_hit;

  logic [PROD2_BITS-PRODUCT_SHIFT-1:0] correction;
  logic [PROD2_BITS-PRODUCT_SHIFT:0]   height_sum;
  logic [COUNT_BITS-1:0]               height_sat;

  always_comb begin
    v_s           = widen(sample);
    trig_s        = widen(trigger_level);
    last_s        = widen(last_sample);
    before_s      = widen(sample_before_last);
    peak_s        = widen(peak_height);
    over          = v_s - trig_s;
    rise_step     = v_s - last_s;
    three_quarter = peak_s - (peak_s >>> 2) - diff_t'(FALL_MARGIN);
    fall_lhs      = (last_s - v_s) <<< 1;
    fall_rhs      = (before_s - last_s) - diff_t'(FALL_STEP);
    rise_lhs      = rise_step;
    rise_rhs      = (widen(start_slope) <<< 1) + diff_t'(RISE_STEP);
    start         = 1'b0;
    finish        = 1'b0;
    if (!in_pulse) begin
      start = (over > 0) && (v_s > last_s);
    end else begin
      finish = (v_s < trig_s);
      if (over < three_quarter) begin
        if (fall_lhs < fall_rhs) begin
          finish = 1'b1;
        end
      end else if (rise_lhs > rise_rhs) begin
        start = 1'b1;
      end
    end
    clip_hit = (v_s > diff_t'(CLIP_LEVEL));
  end

  assign status.finish   = in_pulse && !start && finish;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level <= '0;
    end else if (cfg_valid) begin
      trigger_level <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pulse           <= 1'b0;
      peak_height        <= '0;
      width_count        <= '0;
      clip_count         <= '0;
      start_slope        <= '0;
      last_sample        <= '0;
      sample_before_last <= '0;
    end else if (cmd.step) begin
      if (start) begin
        in_pulse    <= 1'b1;
        peak_height <= (over > 0) ? over[SAMPLE_BITS-1:0] : '0;
        width_count <= COUNT_BITS'(1);
        clip_count  <= '0;
        start_slope <= (rise_step > 0) ? rise_step[SAMPLE_BITS-1:0] : '0;
      end else if (finish) begin
        in_pulse <= 1'b0;
      end else if (in_pulse) begin
        if (over > peak_s) begin
          peak_height <= over[SAMPLE_BITS-1:0];
        end
        if (width_count != COUNT_MAX) begin
          width_count <= width_count + 1'b1;
        end
        if (clip_hit && clip_count != COUNT_MAX) begin
          clip_count <= clip_count + 1'b1;
        end
      end
      sample_before_last <= last_sample;
      last_sample        <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_first) begin
      prod_first <= PROD1_BITS'(start_slope) * PROD1_BITS'(clip_count);
    end
    if (cmd.mul_second) begin
      prod_second <= PROD2_BITS'(prod_first) * PROD2_BITS'(clip_count);
    end
  end

  always_comb begin
    if (clip_count > COUNT_BITS'(1)) begin
      correction = prod_second[PROD2_BITS-1:PRODUCT_SHIFT];
    end else begin
      correction = '0;
    end
    height_sum = (PROD2_BITS-PRODUCT_SHIFT+1)'(peak_height)
               + (PROD2_BITS-PRODUCT_SHIFT+1)'(correction);
    if (height_sum > (PROD2_BITS-PRODUCT_SHIFT+1)'(COUNT_MAX)) begin
      height_sat = COUNT_MAX;
    end else begin
      height_sat = height_sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pulse_width   <= width_count;
      pulse_height  <= height_sat;
      clipped_count <= clip_count;
      rise_slope    <= start_slope;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

  a_pulse_has_width: assert property (@(posedge clk) disable iff (rst)
    in_pulse |-> (width_count != '0))
    else $error("pulse in progress with zero width");

  a_finish_clears_pulse: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.finish) |=> !in_pulse)
    else $error("pulse did not end on its ending sample");

endmodule

`default_nettype wire
